// ===== rtl/core/hsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// hsbm_pkg - shared types and constants of the humidity sensor bus master
// Phase codes, register indexes, start pattern and transaction payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package hsbm_pkg;

   // bus phase codes
   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_ST0      = 5'd1,
      PH_ST1      = 5'd2,
      PH_ST2      = 5'd3,
      PH_ST3      = 5'd4,
      PH_ST4      = 5'd5,
      PH_ST5      = 5'd6,
      PH_ST6      = 5'd7,
      PH_WB_LOW   = 5'd8,
      PH_WB_HIGH  = 5'd9,
      PH_ACK_LOW  = 5'd10,
      PH_ACK_HIGH = 5'd11,
      PH_ACK_END  = 5'd12,
      PH_WAIT     = 5'd13,
      PH_RB_PRE   = 5'd14,
      PH_RB_HIGH  = 5'd15,
      PH_RB_LOW   = 5'd16,
      PH_RA_LOW   = 5'd17,
      PH_RA_HIGH  = 5'd18,
      PH_FIN      = 5'd19,
      PH_RS_HIGH  = 5'd20,
      PH_RS_LOW   = 5'd21
   } phase_type;

   // configuration register indexes
   typedef enum logic {
      CSR_TEMP_COMMAND = 1'b0,
      CSR_HUMI_COMMAND = 1'b1
   } csr_index_type;

   localparam logic [7:0] TEMP_COMMAND_RESET = 8'd3;
   localparam logic [7:0] HUMI_COMMAND_RESET = 8'd5;
   localparam logic [3:0] RESET_PULSES       = 4'd9;
   localparam logic [2:0] LAST_BIT           = 3'd7;
   localparam logic [1:0] CHECK_BYTE_INDEX   = 2'd2;

   // start pattern, bit i belongs to start step i
   localparam logic [6:0] START_CLK  = 7'b0110110;
   localparam logic [6:0] START_PULL = 7'b0011100;

   typedef struct packed {
      logic start_request;
      logic mode;
      logic link_reset;
      logic data_pin;
   } req_payload_type;

   typedef struct packed {
      logic        clock_level;
      logic        data_pull_low;
      logic        busy_res;
      logic        done_res;
      logic        nack_error;
      logic [15:0] reading;
      logic [7:0]  check_byte;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/hsbm_if.sv =====
// ----------------------------------------------------------------------------
// hsbm_if - valid/ready channels of the humidity sensor bus master
// One interface for phase ticks in, one for phase results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsbm_req_if;
   logic                      valid;
   logic                      ready;
   hsbm_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hsbm_rsp_if;
   logic                      valid;
   logic                      ready;
   hsbm_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/humidity_sensor_bus_master.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_bus_master - two-wire humidity sensor bus master
// Steps one bus phase per request transaction: start pattern, command byte,
// acknowledge, wait for the sensor, two data bytes and a checksum byte, with
// a nine-pulse link reset after a missing acknowledge.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            carries
//   req_bus   in         valid/ready          start_request, mode, link_reset, data_pin
//   rsp_bus   out        valid/ready          SCK/DATA levels, busy, done, error, data
//   APB       in/out     psel/penable/pready  temp_command (0x0), humi_command (0x4)
//
// One phase tick per cycle while not stalled: each transaction updates the phase state and
// writes its result into the output register in the same cycle.
// The result is held in the output register; no clearing pass.
// Synchronous reset puts the sequencer in idle and the commands at 3 and 5.
// A stalled result holds the output register; req_bus.ready drops only
// while a result waits and rsp_bus.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_bus_master (
   input  wire logic        clock,
   input  wire logic        reset,
   hsbm_req_if.sink         req_bus,
   hsbm_rsp_if.source       rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import hsbm_pkg::*;

   // sequencer state
   phase_type       phase_ff, phase_in;
   logic [2:0]      bit_count_ff, bit_count_in;
   logic [1:0]      byte_count_ff, byte_count_in;
   logic [3:0]      pulse_count_ff, pulse_count_in;
   logic [7:0]      shift_ff, shift_in;
   logic [15:0]     value_ff, value_in;
   logic [7:0]      checksum_ff, checksum_in;
   logic            error_ff, error_in;
   logic            mode_ff, mode_in;

   // configuration
   logic [7:0]      temp_command_ff, humi_command_ff;
   csr_index_type   csr_index;
   logic            csr_write;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            accept;
   logic [2:0]      start_idx;
   logic [3:0]      pulse_next;
   logic            clk_level, pull_low, busy, done;

   // -------------------------------------------------------------------------
   // APB register file: writes complete in the access phase, no wait states
   // -------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_command_ff <= TEMP_COMMAND_RESET;
         humi_command_ff <= HUMI_COMMAND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEMP_COMMAND: temp_command_ff <= pwdata[7:0];
            CSR_HUMI_COMMAND: humi_command_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_TEMP_COMMAND: prdata = {24'd0, temp_command_ff};
         CSR_HUMI_COMMAND: prdata = {24'd0, humi_command_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Handshake: take a new tick whenever the output register is free or
   // is being emptied in this cycle
   // -------------------------------------------------------------------------
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // step within the start pattern, only meaningful in PH_ST0..PH_ST6
   assign start_idx  = 3'(5'(phase_ff) - 5'(PH_ST0));
   assign pulse_next = pulse_count_ff + 4'd1;

   // -------------------------------------------------------------------------
   // Phase sequencer: next state and the levels driven in this phase
   // -------------------------------------------------------------------------
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      byte_count_in  = byte_count_ff;
      pulse_count_in = pulse_count_ff;
      shift_in       = shift_ff;
      value_in       = value_ff;
      checksum_in    = checksum_ff;
      error_in       = error_ff;
      mode_in        = mode_ff;
      clk_level      = 1'b0;
      pull_low       = 1'b0;
      busy           = 1'b1;
      done           = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            busy = 1'b0;
            if (req_bus.payload.start_request) begin
               // latch the mode and clear the error of the last run
               mode_in        = req_bus.payload.mode;
               error_in       = 1'b0;
               bit_count_in   = '0;
               byte_count_in  = '0;
               pulse_count_in = '0;
               busy           = 1'b1;
               phase_in       = PH_ST0;
            end else if (req_bus.payload.link_reset) begin
               pulse_count_in = '0;
               busy           = 1'b1;
               phase_in       = PH_RS_HIGH;
            end
         end
         PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5: begin
            clk_level = START_CLK[start_idx];
            pull_low  = START_PULL[start_idx];
            phase_in  = phase_type'(5'(phase_ff) + 5'd1);
         end
         PH_ST6: begin
            clk_level = START_CLK[start_idx];
            pull_low  = START_PULL[start_idx];
            if (pulse_count_ff >= RESET_PULSES) begin
               // end of a link reset
               pulse_count_in = '0;
               phase_in       = PH_IDLE;
            end else begin
               shift_in     = mode_ff ? temp_command_ff : humi_command_ff;
               bit_count_in = '0;
               phase_in     = PH_WB_LOW;
            end
         end
         PH_WB_LOW: begin
            pull_low = !shift_ff[7];
            phase_in = PH_WB_HIGH;
         end
         PH_WB_HIGH: begin
            clk_level = 1'b1;
            pull_low  = !shift_ff[7];
            shift_in  = {shift_ff[6:0], 1'b0};
            if (bit_count_ff == LAST_BIT) begin
               bit_count_in = '0;
               phase_in     = PH_ACK_LOW;
            end else begin
               bit_count_in = bit_count_ff + 3'd1;
               phase_in     = PH_WB_LOW;
            end
         end
         PH_ACK_LOW: begin
            phase_in = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            clk_level = 1'b1;
            if (req_bus.payload.data_pin) begin
               error_in = 1'b1;
            end
            phase_in = PH_ACK_END;
         end
         PH_ACK_END: begin
            if (error_ff) begin
               pulse_count_in = '0;
               phase_in       = PH_RS_HIGH;
            end else begin
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!req_bus.payload.data_pin) begin
               byte_count_in = '0;
               phase_in      = PH_RB_PRE;
            end
         end
         PH_RB_PRE: begin
            shift_in     = '0;
            bit_count_in = '0;
            phase_in     = PH_RB_HIGH;
         end
         PH_RB_HIGH: begin
            clk_level = 1'b1;
            shift_in  = {shift_ff[6:0], req_bus.payload.data_pin};
            phase_in  = PH_RB_LOW;
         end
         PH_RB_LOW: begin
            if (bit_count_ff == LAST_BIT) begin
               bit_count_in = '0;
               if (byte_count_ff == 2'd0) begin
                  value_in[15:8] = shift_ff;
               end else if (byte_count_ff == 2'd1) begin
                  value_in[7:0] = shift_ff;
               end else begin
                  checksum_in = shift_ff;
               end
               phase_in = PH_RA_LOW;
            end else begin
               bit_count_in = bit_count_ff + 3'd1;
               phase_in     = PH_RB_HIGH;
            end
         end
         PH_RA_LOW: begin
            pull_low = byte_count_ff < CHECK_BYTE_INDEX;
            phase_in = PH_RA_HIGH;
         end
         PH_RA_HIGH: begin
            clk_level = 1'b1;
            pull_low  = byte_count_ff < CHECK_BYTE_INDEX;
            if (byte_count_ff >= CHECK_BYTE_INDEX) begin
               byte_count_in = '0;
               phase_in      = PH_FIN;
            end else begin
               byte_count_in = byte_count_ff + 2'd1;
               phase_in      = PH_RB_PRE;
            end
         end
         PH_FIN: begin
            busy     = 1'b0;
            done     = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_RS_HIGH: begin
            clk_level = 1'b1;
            phase_in  = PH_RS_LOW;
         end
         PH_RS_LOW: begin
            // after nine pulses, send the start pattern and stop
            if (pulse_next >= RESET_PULSES) begin
               pulse_count_in = RESET_PULSES;
               phase_in       = PH_ST0;
            end else begin
               pulse_count_in = pulse_next;
               phase_in       = PH_RS_HIGH;
            end
         end
         default: begin
            busy     = 1'b0;
            phase_in = PH_IDLE;
         end
      endcase

      rsp_payload_in.clock_level   = clk_level;
      rsp_payload_in.data_pull_low = pull_low;
      rsp_payload_in.busy_res      = busy;
      rsp_payload_in.done_res      = done;
      rsp_payload_in.nack_error    = error_in;
      rsp_payload_in.reading       = value_in;
      rsp_payload_in.check_byte    = checksum_in;
   end

   // -------------------------------------------------------------------------
   // State registers: advance on every accepted tick
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         byte_count_ff  <= '0;
         pulse_count_ff <= '0;
         shift_ff       <= '0;
         value_ff       <= '0;
         checksum_ff    <= '0;
         error_ff       <= 1'b0;
         mode_ff        <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         byte_count_ff  <= byte_count_in;
         pulse_count_ff <= pulse_count_in;
         shift_ff       <= shift_in;
         value_ff       <= value_in;
         checksum_ff    <= checksum_in;
         error_ff       <= error_in;
         mode_ff        <= mode_in;
      end
   end

   // -------------------------------------------------------------------------
   // Output register: load on accept, hold while stalled, drop when taken
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

`ifndef SYNTH
   // a finished measurement never reports busy or an acknowledge error
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.done_res |->
         !rsp_payload_ff.busy_res && !rsp_payload_ff.nack_error)
      else $error("done reported with busy or error set");

   // the link reset pulse counter never runs past nine
   a_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      pulse_count_ff <= RESET_PULSES)
      else $error("reset pulse count out of range");

   // every accepted tick leaves a result in the output register
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // the sensor pulling DATA low ends the wait
   a_wait_exit: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_WAIT && !req_bus.payload.data_pin |=>
         phase_ff == PH_RB_PRE)
      else $error("wait phase missed the sensor response");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - testbench of the humidity sensor bus master
// Feeds bus phase ticks while a behavioural sensor answers on the DATA pin.
// Runs measurements, missing acknowledges, link resets and command register
// changes, then random traffic. A cycle-level predictor checks every result
// transaction field by field against the expected SCK/DATA levels and flags.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsbm_pkg::*;

   localparam int         TICK_TARGET      = 1450;
   localparam int         STALL_LIMIT      = 1000;
   localparam int         MAX_REPORTS      = 30;
   localparam logic [3:0] LINK_PULSES      = 4'd9;
   // start pattern, bit i belongs to start step i
   localparam logic [6:0] SCK_START        = 7'b0110110;
   localparam logic [6:0] PULL_START       = 7'b0011100;
   localparam logic       MODE_HUMIDITY    = 1'b0;
   localparam logic       MODE_TEMPERATURE = 1'b1;
   localparam logic [1:0] BYTE_HIGH        = 2'd0;
   localparam logic [1:0] BYTE_LOW         = 2'd1;

   typedef enum int {RX_STEADY, RX_COIN, RX_SLUGGISH} rx_style_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   hsbm_req_if req_bus ();
   hsbm_rsp_if rsp_bus ();

   humidity_sensor_bus_master i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted sequencer state, mirrored command registers
   phase_type   bus_phase;
   logic [2:0]  bit_cnt;
   logic [1:0]  byte_cnt;
   logic [3:0]  pulse_cnt;
   logic [7:0]  shifter;
   logic [15:0] reading_reg;
   logic [7:0]  check_reg;
   logic        nack_seen;
   logic        temp_mode;
   logic [7:0]  temp_cmd;
   logic [7:0]  humi_cmd;

   // Expected result transactions, oldest first
   rsp_payload_type pending_levels[$];

   int           mismatch_count = 0;
   int           ticks_sent     = 0;
   int           results_seen   = 0;
   int           burst_left     = 0;
   int           idle_cycles    = 0;
   int           rx_left        = 0;
   rx_style_type rx_style       = RX_STEADY;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: advance one bus phase for an accepted tick and return the
   // levels and flags that the block must report for it.
   // ------------------------------------------------------------------------
   function automatic rsp_payload_type advance_phase(input req_payload_type t);
      rsp_payload_type r;
      int              step;
      r          = '0;
      r.busy_res = 1'b1;
      case (bus_phase)
         PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5, PH_ST6: begin
            step            = int'(bus_phase) - int'(PH_ST0);
            r.clock_level   = SCK_START[step];
            r.data_pull_low = PULL_START[step];
            if (bus_phase != PH_ST6) begin
               bus_phase = phase_type'(bus_phase + 5'd1);
            end else if (pulse_cnt >= LINK_PULSES) begin
               // start pattern closing a link reset: back to idle
               pulse_cnt = '0;
               bus_phase = PH_IDLE;
            end else begin
               shifter   = temp_mode ? temp_cmd : humi_cmd;
               bit_cnt   = '0;
               bus_phase = PH_WB_LOW;
            end
         end
         PH_WB_LOW: begin
            r.data_pull_low = ~shifter[7];
            bus_phase       = PH_WB_HIGH;
         end
         PH_WB_HIGH: begin
            r.clock_level   = 1'b1;
            r.data_pull_low = ~shifter[7];
            shifter         = {shifter[6:0], 1'b0};
            if (bit_cnt == 3'd7) begin
               bit_cnt   = '0;
               bus_phase = PH_ACK_LOW;
            end else begin
               bit_cnt   = bit_cnt + 3'd1;
               bus_phase = PH_WB_LOW;
            end
         end
         PH_ACK_LOW: bus_phase = PH_ACK_HIGH;
         PH_ACK_HIGH: begin
            r.clock_level = 1'b1;
            if (t.data_pin) nack_seen = 1'b1;
            bus_phase = PH_ACK_END;
         end
         PH_ACK_END: begin
            if (nack_seen) begin
               pulse_cnt = '0;
               bus_phase = PH_RS_HIGH;
            end else begin
               bus_phase = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!t.data_pin) begin
               byte_cnt  = '0;
               bus_phase = PH_RB_PRE;
            end
         end
         PH_RB_PRE: begin
            shifter   = '0;
            bit_cnt   = '0;
            bus_phase = PH_RB_HIGH;
         end
         PH_RB_HIGH: begin
            r.clock_level = 1'b1;
            shifter       = {shifter[6:0], t.data_pin};
            bus_phase     = PH_RB_LOW;
         end
         PH_RB_LOW: begin
            if (bit_cnt == 3'd7) begin
               bit_cnt = '0;
               case (byte_cnt)
                  BYTE_HIGH: reading_reg[15:8] = shifter;
                  BYTE_LOW:  reading_reg[7:0]  = shifter;
                  default:   check_reg         = shifter;
               endcase
               bus_phase = PH_RA_LOW;
            end else begin
               bit_cnt   = bit_cnt + 3'd1;
               bus_phase = PH_RB_HIGH;
            end
         end
         PH_RA_LOW: begin
            // acknowledge the data bytes, leave the checksum unacknowledged
            r.data_pull_low = (byte_cnt < 2'd2);
            bus_phase       = PH_RA_HIGH;
         end
         PH_RA_HIGH: begin
            r.clock_level   = 1'b1;
            r.data_pull_low = (byte_cnt < 2'd2);
            if (byte_cnt >= 2'd2) begin
               byte_cnt  = '0;
               bus_phase = PH_FIN;
            end else begin
               byte_cnt  = byte_cnt + 2'd1;
               bus_phase = PH_RB_PRE;
            end
         end
         PH_FIN: begin
            r.busy_res = 1'b0;
            r.done_res = 1'b1;
            bus_phase  = PH_IDLE;
         end
         PH_RS_HIGH: begin
            r.clock_level = 1'b1;
            bus_phase     = PH_RS_LOW;
         end
         PH_RS_LOW: begin
            pulse_cnt = pulse_cnt + 4'd1;
            if (pulse_cnt >= LINK_PULSES) begin
               pulse_cnt = LINK_PULSES;
               bus_phase = PH_ST0;
            end else begin
               bus_phase = PH_RS_HIGH;
            end
         end
         PH_IDLE: begin
            r.busy_res = 1'b0;
            // a start request beats a link reset request
            if (t.start_request) begin
               temp_mode  = t.mode;
               nack_seen  = 1'b0;
               bit_cnt    = '0;
               byte_cnt   = '0;
               pulse_cnt  = '0;
               r.busy_res = 1'b1;
               bus_phase  = PH_ST0;
            end else if (t.link_reset) begin
               pulse_cnt  = '0;
               r.busy_res = 1'b1;
               bus_phase  = PH_RS_HIGH;
            end
         end
         default: begin
            r.busy_res = 1'b0;
            bus_phase  = PH_IDLE;
         end
      endcase
      r.nack_error = nack_seen;
      r.reading    = reading_reg;
      r.check_byte = check_reg;
      return r;
   endfunction

   function automatic req_payload_type tick(input logic start, input logic mode,
                                            input logic link, input logic pin);
      req_payload_type t;
      t.start_request = start;
      t.mode          = mode;
      t.link_reset    = link;
      t.data_pin      = pin;
      return t;
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                 results_seen, name, got, want));
   endtask

   // ------------------------------------------------------------------------
   // Send one tick and record its expected result once accepted. Work in
   // bursts: at the end of a burst drop valid for a random gap.
   // ------------------------------------------------------------------------
   task automatic send_tick(input req_payload_type t);
      req_bus.valid   <= 1'b1;
      req_bus.payload <= t;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      pending_levels.push_back(advance_phase(t));
      ticks_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Hold the sender until every expected result transaction has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_command(input csr_index_type idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      // garbage above the command byte must be dropped
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == CSR_TEMP_COMMAND) temp_cmd = value;
      else humi_cmd = value;
      @(posedge clock);
   endtask

   // Reprogram both commands with the sequencer idle and nothing in flight.
   task automatic program_commands(input logic [7:0] temp, input logic [7:0] humi);
      wait_drained();
      repeat (2) @(posedge clock);
      write_command(CSR_TEMP_COMMAND, temp);
      write_command(CSR_HUMI_COMMAND, humi);
   endtask

   // ------------------------------------------------------------------------
   // Run one sequence from idle: send the opening tick, then keep ticking
   // until the predictor is back in idle. The sensor drives DATA from the
   // predicted phase: acknowledge level, a wait of wait_len high ticks, and
   // the 24 bits of sensor_bytes MSB first. Other ticks carry noise.
   // Hold for the results after pause_at ticks when it is positive.
   // ------------------------------------------------------------------------
   task automatic run_sequence(input req_payload_type opener, input logic ack_level,
                               input int wait_len, input logic [23:0] sensor_bytes,
                               input int pause_at);
      req_payload_type t;
      int              waits_left;
      int              bit_idx;
      int              n;
      waits_left = wait_len;
      bit_idx    = 0;
      n          = 0;
      send_tick(opener);
      while (bus_phase != PH_IDLE) begin
         t = req_payload_type'($urandom_range(0, 15));
         case (bus_phase)
            PH_ACK_HIGH: t.data_pin = ack_level;
            PH_WAIT: begin
               t.data_pin = (waits_left > 0);
               if (waits_left > 0) waits_left--;
            end
            PH_RB_HIGH: begin
               t.data_pin = (bit_idx < 24) ? sensor_bytes[23 - bit_idx] : 1'b0;
               bit_idx++;
            end
            default: ;
         endcase
         send_tick(t);
         n++;
         if (n == pause_at) wait_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_idle_ticks();
      send_tick(tick(1'b0, MODE_HUMIDITY, 1'b0, 1'b0));
      send_tick(tick(1'b0, MODE_TEMPERATURE, 1'b0, 1'b1));
   endtask

   task automatic test_measurement_extremes();
      run_sequence(tick(1'b1, MODE_HUMIDITY, 1'b0, 1'b1), 1'b0, 0, 24'hFFFFFF, -1);
      // both requests at once: the measurement must win
      run_sequence(tick(1'b1, MODE_TEMPERATURE, 1'b1, 1'b0), 1'b0, 3, 24'h000000, -1);
   endtask

   task automatic test_missing_ack();
      run_sequence(tick(1'b1, MODE_TEMPERATURE, 1'b0, 1'b0), 1'b1, 0, 24'hA5A5A5, -1);
      // the error flag survives idle and a bare link reset
      send_tick(tick(1'b0, MODE_HUMIDITY, 1'b0, 1'b1));
      run_sequence(tick(1'b0, MODE_HUMIDITY, 1'b1, 1'b1), 1'b0, 0, 24'h0, -1);
      send_tick(tick(1'b0, MODE_HUMIDITY, 1'b0, 1'b0));
      // a new measurement clears it, readings kept from before until then
      run_sequence(tick(1'b1, MODE_HUMIDITY, 1'b0, 1'b0), 1'b0, 1, 24'h5A3C96, -1);
   endtask

   task automatic test_slow_sensor();
      run_sequence(tick(1'b1, MODE_TEMPERATURE, 1'b0, 1'b1), 1'b0, 40, 24'h8001FE, -1);
   endtask

   task automatic test_command_registers();
      program_commands(8'h00, 8'hFF);
      run_sequence(tick(1'b1, MODE_TEMPERATURE, 1'b0, 1'b0), 1'b0, 0, 24'h123456, -1);
      run_sequence(tick(1'b1, MODE_HUMIDITY, 1'b0, 1'b0), 1'b0, 2, 24'hFEDCBA, -1);
      program_commands(8'hFF, 8'h00);
      run_sequence(tick(1'b1, MODE_TEMPERATURE, 1'b0, 1'b1), 1'b0, 1, 24'h0F0F0F, -1);
      run_sequence(tick(1'b1, MODE_HUMIDITY, 1'b0, 1'b1), 1'b0, 0, 24'hF0F0F0, -1);
      program_commands(8'h80, 8'h7F);
      run_sequence(tick(1'b1, MODE_TEMPERATURE, 1'b0, 1'b0), 1'b0, 0, 24'($urandom), -1);
      run_sequence(tick(1'b1, MODE_HUMIDITY, 1'b0, 1'b0), 1'b0, 0, 24'($urandom), -1);
   endtask

   // Hold the sender part way through a measurement until all results are in.
   task automatic test_hold_mid_measurement();
      run_sequence(tick(1'b1, MODE_HUMIDITY, 1'b0, 1'b0), 1'b0, 2, 24'($urandom), 37);
   endtask

   task automatic test_random_traffic();
      req_payload_type opener;
      logic [7:0]      temp_pick;
      logic [7:0]      humi_pick;
      logic            ack_level;
      int              kind;
      int              sequences;
      sequences = 0;
      while (ticks_sent < TICK_TARGET) begin
         if (sequences % 12 == 11) begin
            temp_pick = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            humi_pick = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            program_commands(temp_pick, humi_pick);
         end
         kind      = $urandom_range(0, 99);
         opener    = req_payload_type'($urandom_range(0, 15));
         ack_level = ($urandom_range(0, 7) == 0);
         if (kind < 10) begin
            // bare link reset
            opener.start_request = 1'b0;
            opener.link_reset    = 1'b1;
         end else if (kind < 25) begin
            // noise: any opener, a sensor that may well not answer
            ack_level = 1'($urandom_range(0, 1));
         end else begin
            opener.start_request = 1'b1;
         end
         run_sequence(opener, ack_level, $urandom_range(0, 6), 24'($urandom),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(1, 90) : -1);
         sequences++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result receiver: switch between always ready, coin toss and mostly
   // stalled, each style for a random stretch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_style      <= RX_STEADY;
         rx_left       <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_style <= rx_style_type'($urandom_range(0, 2));
            rx_left  <= $urandom_range(16, 160);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_style)
            RX_STEADY: rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            default:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Compare every result transaction with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         results_seen++;
         if (pending_levels.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
         end else begin
            want = pending_levels.pop_front();
            compare_field("clock_level", 16'(got.clock_level), 16'(want.clock_level));
            compare_field("data_pull_low", 16'(got.data_pull_low),
                          16'(want.data_pull_low));
            compare_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
            compare_field("done_res", 16'(got.done_res), 16'(want.done_res));
            compare_field("nack_error", 16'(got.nack_error), 16'(want.nack_error));
            compare_field("reading", got.reading, want.reading);
            compare_field("check_byte", 16'(got.check_byte), 16'(want.check_byte));
         end
      end
   end

   // Watchdog: drop the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // drive every input to a known value from the start
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      // predictor state after reset
      bus_phase   = PH_IDLE;
      bit_cnt     = '0;
      byte_cnt    = '0;
      pulse_cnt   = '0;
      shifter     = '0;
      reading_reg = '0;
      check_reg   = '0;
      nack_seen   = 1'b0;
      temp_mode   = MODE_HUMIDITY;
      temp_cmd    = TEMP_COMMAND_RESET;
      humi_cmd    = HUMI_COMMAND_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_measurement_extremes();
      test_missing_ack();
      test_slow_sensor();
      test_hold_mid_measurement();
      test_command_registers();
      test_random_traffic();

      // let the last results drain, then watch for stray ones
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_levels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== humidity_sensor_bus_master.f =====
rtl/core/hsbm_pkg.sv
rtl/core/hsbm_if.sv
rtl/core/humidity_sensor_bus_master.sv
test/tb.sv
